/* hdl/cdt_pkg.sv */
// Shared types and codes for the table sampler.
`default_nettype none
package cdt_pkg;

   // Item kinds carried on tuser
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_RAND   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Fraction bytes stored per entry
   localparam int FRAC_BYTES = 4;

   // One queued command from the front end
   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        table_req;
      logic [7:0]        entry_index;
      logic [15:0]       entry_value;
      logic signed [5:0] entry_offset;
      logic [31:0]       entry_fraction;
      logic              last_entry;
      logic [7:0]        random_byte;
   } cmd_type;

   // Status from the search engine
   typedef struct packed {
      logic cmp_active;
      logic bounds_open;
      logic count_ok;
   } back_stat_type;

endpackage
`default_nettype wire

/* hdl/cdt_sampler_lazy_random_top.sv */
// Top level of the cumulative distribution table sampler.
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata items, tuser kind, tlast last_entry
//  rsp     | out | rsp_tvalid/tready  | tdata sample, bytes_used
// A load is written to the entry RAM as it is popped; a start or random byte
// runs search steps of check, wait and compare states, comparing matching bytes
// in turn, then check, value wait and emit. The entry RAM read port sets the wait.
// Reset is synchronous; tables become empty, entry contents are undefined.
// A four-deep command queue lets inputs arrive while the engine or rsp stalls.
`default_nettype none
module cdt_sampler_lazy_random_top #(
   parameter int TABLES           = 8,
   parameter int ENTRIES          = 256,
   parameter int MAX_RANDOM_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // table_req, entry_index, entry_value, entry_offset, entry_fraction,
   // random_byte (from bit 0 up), zero fill
   input  wire logic [79:0] req_tdata,
   // kind
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // sample, bytes_used (from bit 0 up), zero fill
   output      logic [23:0] rsp_tdata
);

   cdt_pkg::cmd_type       cmd;
   logic                   cmd_valid, cmd_pop;
   cdt_pkg::back_stat_type stat;

   cdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop)
   );

   cdt_back #(
      .TABLES           (TABLES),
      .ENTRIES          (ENTRIES),
      .MAX_RANDOM_BYTES (MAX_RANDOM_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .stat       (stat)
   );

`ifndef SYNTHESIS
   // A byte compare runs only while the search interval is still open
   a_cmp_open: assert property (@(posedge clock) disable iff (reset)
      stat.cmp_active |-> stat.bounds_open)
      else $error("compare with closed bounds");
   // Random byte count never exceeds the store
   a_count: assert property (@(posedge clock) disable iff (reset)
      stat.count_ok)
      else $error("random count overflow");
   // Commands are popped only when queued
   a_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* hdl/cdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* hdl/cdt_front.sv */
// Front end: accepts stream items, drops unused kinds, queues commands.
`default_nettype none
module cdt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [79:0]      req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             req_tlast,
   output      cdt_pkg::cmd_type cmd,
   output      logic             cmd_valid,
   input  wire logic             cmd_pop
);

   localparam int QDEPTH = 4;

   cdt_pkg::cmd_type queue_ff [QDEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] level_ff, level_in;
   cdt_pkg::cmd_type item;
   logic push;

   // Unpack the transfer
   always_comb begin
      item.kind           = req_tuser;
      item.table_req      = req_tdata[2:0];
      item.entry_index    = req_tdata[10:3];
      item.entry_value    = req_tdata[26:11];
      item.entry_offset   = $signed(req_tdata[32:27]);
      item.entry_fraction = req_tdata[64:33];
      item.random_byte    = req_tdata[72:65];
      item.last_entry     = req_tlast;
   end

   assign req_tready = (level_ff != 3'(QDEPTH));
   // Drop the unused kind at the door
   assign push       = req_tvalid && req_tready &&
                       (req_tuser == cdt_pkg::KIND_LOAD ||
                        req_tuser == cdt_pkg::KIND_START ||
                        req_tuser == cdt_pkg::KIND_RAND);
   assign cmd_valid  = (level_ff != 3'd0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Advance pointers and level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      level_in  = level_ff + 3'(push) - 3'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

/* hdl/cdt_back.sv */
// Back end: table loads, binary search over random bytes, result register.
`default_nettype none
module cdt_back #(
   parameter int TABLES           = 8,
   parameter int ENTRIES          = 256,
   parameter int MAX_RANDOM_BYTES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cdt_pkg::cmd_type       cmd,
   input  wire logic                   cmd_valid,
   output      logic                   cmd_pop,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [23:0]            rsp_tdata,
   output      cdt_pkg::back_stat_type stat
);

   localparam int ADDR_W = $clog2(TABLES * ENTRIES);
   localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int CNT_W  = $clog2(MAX_RANDOM_BYTES + 1);
   localparam int SIDX_W = $clog2(MAX_RANDOM_BYTES);
   localparam int ENT_W  = 16 + 6 + 32;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_VWAIT = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic signed [9:0]       low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic [CNT_W-1:0]        pos_ff, pos_in, count_ff, count_in;
   logic [TBL_W-1:0]        tbl_ff, tbl_in;
   logic                    searching_ff, searching_in;
   logic                    zero_ff, zero_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [8:0]              sizes_ff [TABLES];
   logic [7:0]              store_ff [MAX_RANDOM_BYTES];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             sample_ff;
   logic [5:0]              used_ff;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ENT_W-1:0]        rd_data;
   logic [15:0]             ent_value;
   logic signed [5:0]       ent_off;
   logic [31:0]             ent_frac;
   logic [TBL_W-1:0]        sel;
   logic                    tbl_ok, idx_ok;
   logic signed [10:0]      gap, mid_sum;
   logic signed [8:0]       rel;
   logic [7:0]              cbyte, rbyte;
   logic                    out_free, size_wr, store_wr, take_emit;

   assign {ent_value, ent_off, ent_frac} = rd_data;
   assign sel      = TBL_W'(cmd.table_req);
   assign tbl_ok   = 32'(cmd.table_req) < TABLES;
   assign idx_ok   = 32'(cmd.entry_index) < ENTRIES;
   assign gap      = 11'(high_ff) - 11'(low_ff);
   assign mid_sum  = 11'(high_ff) + 11'(low_ff);
   assign rel      = $signed(9'(pos_ff)) - 9'(ent_off);
   assign rbyte    = store_ff[pos_ff[SIDX_W-1:0]];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cmd_pop  = (state_ff == S_IDLE) && cmd_valid;
   assign wr_en    = cmd_pop && cmd.kind == cdt_pkg::KIND_LOAD && tbl_ok && idx_ok;
   assign wr_addr  = ADDR_W'(sel) * ADDR_W'(ENTRIES) + ADDR_W'(cmd.entry_index);
   assign size_wr  = wr_en && cmd.last_entry;
   assign store_wr = cmd_pop && cmd.kind == cdt_pkg::KIND_RAND && searching_ff &&
                     32'(count_ff) < MAX_RANDOM_BYTES;
   assign take_emit = (state_ff == S_EMIT) && out_free;

   // Pick the entry byte at the current position
   always_comb begin
      case (rel[1:0])
         2'd0:    cbyte = ent_frac[31:24];
         2'd1:    cbyte = ent_frac[23:16];
         2'd2:    cbyte = ent_frac[15:8];
         default: cbyte = ent_frac[7:0];
      endcase
      if (rel < 0 || rel > 9'(cdt_pkg::FRAC_BYTES - 1)) begin
         cbyte = 8'd0;
      end
   end

   // Search sequencer
   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      tbl_in       = tbl_ff;
      searching_in = searching_ff;
      zero_in      = zero_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == cdt_pkg::KIND_START) begin
                  tbl_in       = tbl_ok ? sel : '0;
                  high_in      = (tbl_ok ? $signed({1'b0, sizes_ff[sel]}) : 10'sd0) - 10'sd1;
                  low_in       = -10'sd1;
                  pos_in       = '0;
                  count_in     = '0;
                  searching_in = 1'b1;
                  state_in     = S_CHECK;
               end else if (cmd.kind == cdt_pkg::KIND_RAND && searching_ff) begin
                  if (store_wr) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (gap > 11'sd1) begin
               mid_in   = 10'(mid_sum >>> 1);
               addr_in  = ADDR_W'(tbl_ff) * ADDR_W'(ENTRIES) + ADDR_W'(mid_in[8:0]);
               state_in = S_WAIT;
            end else if (high_ff >= 0) begin
               zero_in  = 1'b0;
               addr_in  = ADDR_W'(tbl_ff) * ADDR_W'(ENTRIES) + ADDR_W'(high_ff[8:0]);
               state_in = S_VWAIT;
            end else begin
               zero_in  = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_WAIT: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (rel >= 9'(cdt_pkg::FRAC_BYTES) || 32'(pos_ff) >= MAX_RANDOM_BYTES) begin
               low_in   = mid_ff;
               pos_in   = '0;
               state_in = S_CHECK;
            end else if (pos_ff >= count_ff) begin
               // Wait for more random bytes, keep the position
               state_in = S_IDLE;
            end else if (rbyte == cbyte) begin
               pos_in = pos_ff + CNT_W'(1);
            end else begin
               if (rbyte < cbyte) begin
                  high_in = mid_ff;
               end else begin
                  low_in = mid_ff;
               end
               pos_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_VWAIT: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               searching_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= -10'sd1;
         high_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         tbl_ff       <= '0;
         searching_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLES; i++) begin
            sizes_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         tbl_ff       <= tbl_in;
         searching_ff <= searching_in;
         rsp_valid_ff <= rsp_valid_in;
         if (size_wr) begin
            sizes_ff[sel] <= 9'(cmd.entry_index) + 9'd1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mid_ff  <= mid_in;
      zero_ff <= zero_in;
      addr_ff <= addr_in;
      if (store_wr) begin
         store_ff[count_ff[SIDX_W-1:0]] <= cmd.random_byte;
      end
      if (take_emit) begin
         sample_ff <= zero_ff ? 16'd0 : ent_value;
         used_ff   <= 6'(count_ff);
      end
   end

   cdt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLES * ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({cmd.entry_value, cmd.entry_offset, cmd.entry_fraction}),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, used_ff, sample_ff};

   assign stat.cmp_active  = (state_ff == S_CMP);
   assign stat.bounds_open = (gap > 11'sd1);
   assign stat.count_ok    = 32'(count_ff) <= MAX_RANDOM_BYTES;

endmodule
`default_nettype wire

/* dv/cdt_sampler_lazy_random_check.sv */
// Checker for the table sampler: watches both channels, predicts samples, compares.
`timescale 1ns / 100ps
module cdt_sampler_lazy_random_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   output int               fail_count,
   output int               pending,
   output logic             xfer_seen
);

   typedef struct packed {
      logic [15:0] sample;
      logic [5:0]  bytes_used;
   } draw_type;

   // Mirror of the sampler's tables and search
   logic [15:0]        ent_value [2048];
   logic signed [5:0]  ent_offset [2048];
   logic [31:0]        ent_frac [2048];
   int                 tab_size [8];
   logic [7:0]         rnd_store [32];
   int                 rnd_count;
   int                 lo_bound;
   int                 hi_bound;
   int                 cmp_pos;
   int                 cur_table;
   bit                 busy;
   draw_type           draw_q[$];

   assign pending   = draw_q.size();
   assign xfer_seen = (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready);

   // Run comparisons until bytes run out (0) or the bounds meet (1)
   function automatic bit search_step();
      int mid, idx, off, pos, rel;
      bit down, stop;
      logic [7:0] cb;
      while (hi_bound - lo_bound > 1) begin
         mid = (lo_bound + hi_bound) / 2;
         idx = cur_table * 256 + mid;
         off = ent_offset[idx];
         pos = cmp_pos;
         stop = 0;
         down = 0;
         while (!stop) begin
            rel = pos - off;
            if (rel >= cdt_pkg::FRAC_BYTES || pos >= 32) begin
               down = 0;
               stop = 1;
            end else if (pos >= rnd_count) begin
               cmp_pos = pos;
               return 0;
            end else begin
               cb = (rel < 0) ? 8'd0 : ent_frac[idx][31 - 8 * rel -: 8];
               if (rnd_store[pos] == cb) begin
                  pos++;
               end else begin
                  down = rnd_store[pos] < cb;
                  stop = 1;
               end
            end
         end
         if (down) hi_bound = mid;
         else lo_bound = mid;
         cmp_pos = 0;
      end
      return 1;
   endfunction

   // Queue the sample at the high bound and go idle
   function automatic void push_draw();
      draw_type d;
      d.sample     = (hi_bound >= 0) ? ent_value[cur_table * 256 + hi_bound] : 16'd0;
      d.bytes_used = rnd_count[5:0];
      draw_q.push_back(d);
      busy = 0;
   endfunction

   // Predict on each request transfer
   always @(posedge clock) begin
      logic [2:0] t;
      logic [7:0] ix;
      int         e;
      if (reset) begin
         for (e = 0; e < 2048; e++) begin
            ent_value[e]  = '0;
            ent_offset[e] = '0;
            ent_frac[e]   = '0;
         end
         for (e = 0; e < 8; e++) tab_size[e] = 0;
         rnd_count = 0;
         lo_bound  = -1;
         hi_bound  = 0;
         cmp_pos   = 0;
         cur_table = 0;
         busy      = 0;
      end else if (req_tvalid && req_tready) begin
         t  = req_tdata[2:0];
         ix = req_tdata[10:3];
         case (req_tuser)
            cdt_pkg::KIND_LOAD: begin
               e = int'(t) * 256 + int'(ix);
               ent_value[e]  = req_tdata[26:11];
               ent_offset[e] = req_tdata[32:27];
               ent_frac[e]   = req_tdata[64:33];
               if (req_tlast) tab_size[t] = int'(ix) + 1;
            end
            cdt_pkg::KIND_START: begin
               cur_table = int'(t);
               rnd_count = 0;
               cmp_pos   = 0;
               lo_bound  = -1;
               hi_bound  = tab_size[t] - 1;
               busy      = 1;
               if (search_step()) push_draw();
            end
            cdt_pkg::KIND_RAND: begin
               if (busy) begin
                  if (rnd_count < 32) begin
                     rnd_store[rnd_count] = req_tdata[72:65];
                     rnd_count++;
                  end
                  if (search_step()) push_draw();
               end
            end
            default: ;
         endcase
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      draw_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.sample     = rsp_tdata[15:0];
         got.bytes_used = rsp_tdata[21:16];
         if (draw_q.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected sample %h bytes_used %0d", got.sample, got.bytes_used);
            fail_count <= fail_count + 1;
         end else begin
            want = draw_q.pop_front();
            if (got !== want || rsp_tdata[23:22] !== 2'b00) begin
               if (fail_count < 10)
                  $display("mismatch: expected sample %h used %0d, got sample %h used %0d",
                           want.sample, want.bytes_used, got.sample, got.bytes_used);
               fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

/* dv/cdt_sampler_lazy_random_top_test.sv */
// Testbench top for the table sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module cdt_sampler_lazy_random_top_test;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   int          fail_count;
   int          pending;
   logic        xfer_seen;
   int          idle_cycles;
   int          burst_left;
   int          items_sent;
   int          loaded [8];

   cdt_sampler_lazy_random_top i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   cdt_sampler_lazy_random_check i_check (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending, .xfer_seen
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Stall the result side in random runs, with some long all-ready stretches
   initial begin
      int run;
      rsp_tready = 1'b0;
      forever begin
         run = $urandom_range(1, 30);
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b0;
            1: begin
               rsp_tready <= 1'b1;
               run = run * 4;
            end
            default: rsp_tready <= 1'b1;
         endcase
         repeat (run) @(posedge clock);
      end
   end

   // End the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || xfer_seen) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Send one request, in bursts with random gaps between them
   task automatic send(input logic [1:0] kind, input logic [2:0] tab, input logic [7:0] ix,
                       input logic [15:0] val, input logic [5:0] off, input logic [31:0] frac,
                       input logic last, input logic [7:0] rb);
      int gap;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {7'd0, rb, frac, off, val, ix, tab};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (kind != cdt_pkg::KIND_UNUSED) items_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Fraction with zero bytes fairly often, so compares carry on to later positions
   function automatic logic [31:0] pick_frac();
      logic [31:0] f;
      f = $urandom;
      for (int b = 0; b < 4; b++)
         if ($urandom_range(0, 3) == 0) f[8 * b +: 8] = 8'h00;
      return f;
   endfunction

   task automatic rand_byte();
      send(cdt_pkg::KIND_RAND, 3'($urandom), 8'($urandom), 16'($urandom), 6'($urandom),
           $urandom, 1'($urandom), pick_byte());
   endtask

   task automatic start(input logic [2:0] tab);
      send(cdt_pkg::KIND_START, tab, 8'($urandom), 16'($urandom), 6'($urandom), $urandom,
           1'($urandom), 8'($urandom));
   endtask

   task automatic load(input logic [2:0] tab, input logic [7:0] ix, input logic last);
      logic [5:0] off;
      off = $urandom_range(0, 1) ? 6'($urandom_range(0, 5)) : 6'($urandom);
      send(cdt_pkg::KIND_LOAD, tab, ix, 16'($urandom), off, pick_frac(), last, 8'($urandom));
      if (int'(ix) == loaded[tab]) loaded[tab]++;
   endtask

   initial begin
      int tab, ix, n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      burst_left = 0;
      items_sent = 0;
      for (int k = 0; k < 8; k++) loaded[k] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: unused kind, idle byte, empty table
      send(cdt_pkg::KIND_UNUSED, 3'd7, 8'hFF, 16'hFFFF, 6'h3F, 32'hFFFFFFFF, 1'b1, 8'hFF);
      rand_byte();
      start(3'd0);
      // Single-entry table answers at once
      send(cdt_pkg::KIND_LOAD, 3'd1, 8'd0, 16'hFFFF, 6'h3D, 32'hFFFFFFFF, 1'b1, 8'h00);
      loaded[1] = 1;
      start(3'd1);
      // Four entries with extreme offsets and fractions
      send(cdt_pkg::KIND_LOAD, 3'd2, 8'd0, 16'h0000, 6'd28, 32'h00000000, 1'b0, 8'h00);
      send(cdt_pkg::KIND_LOAD, 3'd2, 8'd1, 16'h1234, 6'd28, 32'hFFFFFFFF, 1'b0, 8'h00);
      send(cdt_pkg::KIND_LOAD, 3'd2, 8'd2, 16'hABCD, 6'h20, 32'h80000001, 1'b0, 8'h00);
      send(cdt_pkg::KIND_LOAD, 3'd2, 8'd3, 16'h5555, 6'd0, 32'h7F00FF01, 1'b1, 8'h00);
      loaded[2] = 4;
      // Zero bytes run past the store
      start(3'd2);
      repeat (34) send(cdt_pkg::KIND_RAND, 3'd0, 8'd0, 16'd0, 6'd0, 32'd0, 1'b0, 8'h00);
      start(3'd2);
      repeat (5) send(cdt_pkg::KIND_RAND, 3'd0, 8'd0, 16'd0, 6'd0, 32'd0, 1'b0, 8'hFF);
      // Restart mid-search, and a load while a search runs
      start(3'd2);
      send(cdt_pkg::KIND_RAND, 3'd0, 8'd0, 16'd0, 6'd0, 32'd0, 1'b0, 8'h00);
      start(3'd2);
      send(cdt_pkg::KIND_LOAD, 3'd2, 8'd1, 16'hFFFF, 6'd0, 32'h00FFFFFF, 1'b0, 8'h00);
      repeat (4) send(cdt_pkg::KIND_RAND, 3'd0, 8'd0, 16'd0, 6'd0, 32'd0, 1'b0, 8'h00);

      // Fill one table to full size
      for (ix = 0; ix < 256; ix++) load(3'd7, 8'(ix), ix == 255);

      // Random: mostly complete samples, some loads and noise
      while (items_sent < 1150) begin
         n = $urandom_range(0, 99);
         tab = $urandom_range(0, 7);
         if (n < 15) begin
            if (loaded[tab] >= 20 && tab != 7) ix = $urandom_range(0, loaded[tab] - 1);
            else ix = $urandom_range(0, loaded[tab] > 255 ? 255 : loaded[tab]);
            if ($urandom_range(0, 9) == 0) begin
               send(cdt_pkg::KIND_LOAD, 3'(tab), 8'hFF, 16'($urandom), 6'($urandom),
                    pick_frac(), 1'b0, 8'($urandom));
               if (loaded[tab] == 255) loaded[tab] = 256;
            end else begin
               load(3'(tab), 8'(ix),
                    (ix < loaded[tab] || ix == loaded[tab]) && $urandom_range(0, 2) == 0);
            end
         end else if (n < 20) begin
            if ($urandom_range(0, 1)) send(cdt_pkg::KIND_UNUSED, 3'($urandom), 8'($urandom),
                                           16'($urandom), 6'($urandom), $urandom,
                                           1'($urandom), 8'($urandom));
            else rand_byte();
         end else begin
            start(3'(tab));
            n = $urandom_range(0, 5) == 0 ? $urandom_range(0, 4) : $urandom_range(4, 36);
            repeat (n) rand_byte();
         end
      end

      // Drain, then leave room for stray results
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
